// File: hw/rtl/assert_macros.svh
// Assertion helpers used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define CHK_IMPLY(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define CHK_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: hw/rtl/oal_pkg.sv
package oal_pkg;

    localparam int CAPACITY_DEF = 16;
    localparam int DATA_W       = 32;
    localparam int POS_W        = 5;
    localparam int CNT_W        = 5;

    typedef enum logic [1:0] {
        CMD_INSERT = 2'd0,
        CMD_DELETE = 2'd1,
        CMD_LOCATE = 2'd2,
        CMD_SORTED = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        ST_OK     = 2'd0,
        ST_BADPOS = 2'd1,
        ST_FULL   = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        RD_AT    = 2'd0,
        RD_BELOW = 2'd1,
        RD_ABOVE = 2'd2
    } rd_sel_t;

    typedef struct packed {
        logic    capture;
        logic    set_badpos;
        logic    set_full;
        logic    start_ins;
        logic    start_del;
        logic    start_scan;
        logic    start_up;
        logic    idx_inc;
        logic    idx_dec;
        rd_sel_t rd_sel;
        logic    wr_shift;
        logic    put;
        logic    held_dec;
        logic    where_hit;
        logic    load_out;
    } dp_cmd_t;

    typedef struct packed {
        cmd_t cmd;
        logic ins_bad;
        logic del_bad;
        logic full;
        logic up_done;
        logic scan_end;
        logic dn_end;
        logic hit;
    } dp_stat_t;

endpackage

// File: hw/rtl/oal_ram.sv
module oal_ram #(
    parameter int WIDTH = oal_pkg::DATA_W,
    parameter int DEPTH = oal_pkg::CAPACITY_DEF
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// File: hw/rtl/oal_ctrl.sv
module oal_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              s_tvalid,
    output logic              s_tready,
    output logic              m_tvalid,
    input  logic              m_tready,
    input  oal_pkg::dp_stat_t sts,
    output oal_pkg::dp_cmd_t  ctl
);

    typedef enum logic [9:0] {
        S_IDLE   = 10'b0000000001,
        S_CHECK  = 10'b0000000010,
        S_SC_RD  = 10'b0000000100,
        S_SC_CMP = 10'b0000001000,
        S_SU_RD  = 10'b0000010000,
        S_SU_WR  = 10'b0000100000,
        S_SD_RD  = 10'b0001000000,
        S_SD_WR  = 10'b0010000000,
        S_PUT    = 10'b0100000000,
        S_FINISH = 10'b1000000000
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;

    always_comb
    begin
        state_next = state_reg;
        ctl        = '0;
        ctl.rd_sel = oal_pkg::RD_AT;
        case (state_reg)
            S_IDLE:
            begin
                if (s_tvalid)
                begin
                    ctl.capture = 1'b1;
                    state_next  = S_CHECK;
                end
            end
            S_CHECK:
            begin
                case (sts.cmd)
                    oal_pkg::CMD_INSERT:
                    begin
                        if (sts.ins_bad)
                        begin
                            ctl.set_badpos = 1'b1;
                            state_next     = S_FINISH;
                        end
                        else if (sts.full)
                        begin
                            ctl.set_full = 1'b1;
                            state_next   = S_FINISH;
                        end
                        else
                        begin
                            ctl.start_ins = 1'b1;
                            state_next    = S_SU_RD;
                        end
                    end
                    oal_pkg::CMD_DELETE:
                    begin
                        if (sts.del_bad)
                        begin
                            ctl.set_badpos = 1'b1;
                            state_next     = S_FINISH;
                        end
                        else
                        begin
                            ctl.start_del = 1'b1;
                            state_next    = S_SD_RD;
                        end
                    end
                    oal_pkg::CMD_LOCATE:
                    begin
                        ctl.start_scan = 1'b1;
                        state_next     = S_SC_RD;
                    end
                    default:
                    begin
                        if (sts.full)
                        begin
                            ctl.set_full = 1'b1;
                            state_next   = S_FINISH;
                        end
                        else
                        begin
                            ctl.start_scan = 1'b1;
                            state_next     = S_SC_RD;
                        end
                    end
                endcase
            end
            S_SC_RD:
            begin
                if (sts.scan_end)
                begin
                    if (sts.cmd == oal_pkg::CMD_LOCATE)
                    begin
                        state_next = S_FINISH;
                    end
                    else
                    begin
                        ctl.start_up = 1'b1;
                        state_next   = S_SU_RD;
                    end
                end
                else
                begin
                    state_next = S_SC_CMP;
                end
            end
            S_SC_CMP:
            begin
                if (sts.hit)
                begin
                    if (sts.cmd == oal_pkg::CMD_LOCATE)
                    begin
                        ctl.where_hit = 1'b1;
                        state_next    = S_FINISH;
                    end
                    else
                    begin
                        ctl.start_up = 1'b1;
                        state_next   = S_SU_RD;
                    end
                end
                else
                begin
                    ctl.idx_inc = 1'b1;
                    state_next  = S_SC_RD;
                end
            end
            S_SU_RD:
            begin
                if (sts.up_done)
                begin
                    state_next = S_PUT;
                end
                else
                begin
                    ctl.rd_sel = oal_pkg::RD_BELOW;
                    state_next = S_SU_WR;
                end
            end
            S_SU_WR:
            begin
                ctl.wr_shift = 1'b1;
                ctl.idx_dec  = 1'b1;
                state_next   = S_SU_RD;
            end
            S_SD_RD:
            begin
                if (sts.dn_end)
                begin
                    ctl.held_dec = 1'b1;
                    state_next   = S_FINISH;
                end
                else
                begin
                    ctl.rd_sel = oal_pkg::RD_ABOVE;
                    state_next = S_SD_WR;
                end
            end
            S_SD_WR:
            begin
                ctl.wr_shift = 1'b1;
                ctl.idx_inc  = 1'b1;
                state_next   = S_SD_RD;
            end
            S_PUT:
            begin
                ctl.put    = 1'b1;
                state_next = S_FINISH;
            end
            S_FINISH:
            begin
                if (!out_valid_reg || m_tready)
                begin
                    ctl.load_out = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_valid_reg && m_tready)
        begin
            out_valid_next = 1'b0;
        end
        if (ctl.load_out)
        begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = out_valid_reg;

endmodule

// File: hw/rtl/oal_dp.sv
module oal_dp #(
    parameter int CAPACITY = oal_pkg::CAPACITY_DEF
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  oal_pkg::dp_cmd_t           ctl,
    output oal_pkg::dp_stat_t          sts,
    input  logic [1:0]                 in_cmd,
    input  logic [oal_pkg::DATA_W-1:0] in_value,
    input  logic [oal_pkg::POS_W-1:0]  in_position,
    output logic [1:0]                 out_status,
    output logic [oal_pkg::CNT_W-1:0]  out_where,
    output logic [oal_pkg::CNT_W-1:0]  out_fill
);

    localparam int CW = $clog2(CAPACITY + 1);
    localparam int AW = $clog2(CAPACITY);
    localparam int W  = ((CW > oal_pkg::POS_W) ? CW : oal_pkg::POS_W) + 1;

    oal_pkg::cmd_t              cmd_reg, cmd_next;
    logic [oal_pkg::DATA_W-1:0] val_reg, val_next;
    logic [oal_pkg::POS_W-1:0]  pos_reg, pos_next;
    logic [CW-1:0]              held_reg, held_next;
    logic [CW-1:0]              idx_reg, idx_next;
    logic [CW-1:0]              p_reg, p_next;
    logic [CW-1:0]              where_reg, where_next;
    oal_pkg::status_t           status_reg, status_next;
    oal_pkg::status_t           ostat_reg, ostat_next;
    logic [oal_pkg::CNT_W-1:0]  owhere_reg, owhere_next;
    logic [oal_pkg::CNT_W-1:0]  ofill_reg, ofill_next;

    logic [W-1:0]               pos_w;
    logic [W-1:0]               held_w;
    logic [CW-1:0]              pos_m1;
    logic [CW-1:0]              rd_idx;
    logic [oal_pkg::DATA_W-1:0] rd_data;
    logic                       we;
    logic [AW-1:0]              waddr;
    logic [oal_pkg::DATA_W-1:0] wdata;

    assign pos_w  = W'(pos_reg);
    assign held_w = W'(held_reg);
    assign pos_m1 = CW'(pos_w - W'(1));

    assign sts.cmd      = cmd_reg;
    assign sts.ins_bad  = (pos_reg == '0) || (pos_w > held_w + W'(1));
    assign sts.del_bad  = (pos_reg == '0) || (pos_w > held_w);
    assign sts.full     = (held_reg == CW'(CAPACITY));
    assign sts.up_done  = (idx_reg == p_reg);
    assign sts.scan_end = (idx_reg >= held_reg);
    assign sts.dn_end   = ((W'(idx_reg) + W'(1)) >= held_w);
    assign sts.hit      = (cmd_reg == oal_pkg::CMD_LOCATE) ? (rd_data == val_reg)
                                                           : !($signed(rd_data) < $signed(val_reg));

    always_comb
    begin
        case (ctl.rd_sel)
            oal_pkg::RD_BELOW: rd_idx = idx_reg - CW'(1);
            oal_pkg::RD_ABOVE: rd_idx = idx_reg + CW'(1);
            default:           rd_idx = idx_reg;
        endcase
    end

    assign we    = ctl.put | ctl.wr_shift;
    assign waddr = ctl.put ? p_reg[AW-1:0] : idx_reg[AW-1:0];
    assign wdata = ctl.put ? val_reg : rd_data;

    oal_ram #(
        .WIDTH (oal_pkg::DATA_W),
        .DEPTH (CAPACITY)
    ) u_ram (
        .clk   (clk),
        .we    (we),
        .waddr (waddr),
        .wdata (wdata),
        .raddr (rd_idx[AW-1:0]),
        .rdata (rd_data)
    );

    always_comb
    begin
        cmd_next    = cmd_reg;
        val_next    = val_reg;
        pos_next    = pos_reg;
        held_next   = held_reg;
        idx_next    = idx_reg;
        p_next      = p_reg;
        where_next  = where_reg;
        status_next = status_reg;
        ostat_next  = ostat_reg;
        owhere_next = owhere_reg;
        ofill_next  = ofill_reg;

        if (ctl.capture)
        begin
            cmd_next    = oal_pkg::cmd_t'(in_cmd);
            val_next    = in_value;
            pos_next    = in_position;
            where_next  = '0;
            status_next = oal_pkg::ST_OK;
        end
        if (ctl.set_badpos)
        begin
            status_next = oal_pkg::ST_BADPOS;
        end
        if (ctl.set_full)
        begin
            status_next = oal_pkg::ST_FULL;
        end

        if (ctl.start_ins)
        begin
            idx_next = held_reg;
            p_next   = pos_m1;
        end
        else if (ctl.start_up)
        begin
            idx_next = held_reg;
            p_next   = idx_reg;
        end
        else if (ctl.start_del)
        begin
            idx_next = pos_m1;
        end
        else if (ctl.start_scan)
        begin
            idx_next = '0;
        end
        else if (ctl.idx_inc)
        begin
            idx_next = idx_reg + CW'(1);
        end
        else if (ctl.idx_dec)
        begin
            idx_next = idx_reg - CW'(1);
        end

        if (ctl.where_hit)
        begin
            where_next = idx_reg + CW'(1);
        end
        if (ctl.put)
        begin
            where_next = p_reg + CW'(1);
            held_next  = held_reg + CW'(1);
        end
        if (ctl.held_dec)
        begin
            held_next = held_reg - CW'(1);
        end

        if (ctl.load_out)
        begin
            ostat_next  = status_reg;
            owhere_next = oal_pkg::CNT_W'(where_reg);
            ofill_next  = oal_pkg::CNT_W'(held_reg);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_reg <= '0;
        end
        else
        begin
            held_reg <= held_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg    <= cmd_next;
        val_reg    <= val_next;
        pos_reg    <= pos_next;
        idx_reg    <= idx_next;
        p_reg      <= p_next;
        where_reg  <= where_next;
        status_reg <= status_next;
        ostat_reg  <= ostat_next;
        owhere_reg <= owhere_next;
        ofill_reg  <= ofill_next;
    end

    assign out_status = ostat_reg;
    assign out_where  = owhere_reg;
    assign out_fill   = ofill_reg;

endmodule

// File: hw/rtl/ordered_array_list.sv
// Channel  Direction  Ports                              Content
// s        in         s_tvalid s_tready s_tuser s_tdata  one command
// m        out        m_tvalid m_tready m_tdata          one result per command
//
// A command holds the input while it compares or moves entries one at a time through
// the single read port of the entry memory; a sorted insert both scans and shifts entries.
// Reset empties the list at once; there is no clearing pass over the memory.
// A new command is taken as soon as the previous result sits in the output register.
// A stalled output holds the finished command until the previous result transfer completes.
module ordered_array_list #(
    parameter int CAPACITY = oal_pkg::CAPACITY_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [1:0]  s_tuser,   // cmd
    input  logic [39:0] s_tdata,   // value[31:0], position[36:32], zero pad
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata    // status[1:0], where_found[6:2], fill_count[11:7], zero pad
);

    oal_pkg::dp_cmd_t          ctl;
    oal_pkg::dp_stat_t         sts;
    logic [1:0]                status;
    logic [oal_pkg::CNT_W-1:0] where_found;
    logic [oal_pkg::CNT_W-1:0] fill_count;

    oal_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .sts      (sts),
        .ctl      (ctl)
    );

    oal_dp #(
        .CAPACITY (CAPACITY)
    ) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .ctl         (ctl),
        .sts         (sts),
        .in_cmd      (s_tuser),
        .in_value    (s_tdata[31:0]),
        .in_position (s_tdata[36:32]),
        .out_status  (status),
        .out_where   (where_found),
        .out_fill    (fill_count)
    );

    assign m_tdata = {4'b0000, fill_count, where_found, status};

endmodule

// File: hw/rtl/oal_checker.sv
`include "assert_macros.svh"

module oal_checker #(
    parameter int CAPACITY = oal_pkg::CAPACITY_DEF
) (
    input logic        clk,
    input logic        rst_n,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [15:0] m_tdata
);

    `CHK_NEXT(a_out_hold, clk, rst_n, m_tvalid && !m_tready,
        m_tvalid && $stable(m_tdata), "result changed while stalled")
    `CHK_NEXT(a_one_at_a_time, clk, rst_n, s_tvalid && s_tready, !s_tready,
        "command taken while one is in progress")
    `CHK_IMPLY(a_status_code, clk, rst_n, m_tvalid,
        (m_tdata[1:0] == oal_pkg::ST_OK) || (m_tdata[1:0] == oal_pkg::ST_BADPOS) ||
        (m_tdata[1:0] == oal_pkg::ST_FULL), "undefined status code")
    `CHK_IMPLY(a_err_no_where, clk, rst_n, m_tvalid && (m_tdata[1:0] != oal_pkg::ST_OK),
        m_tdata[6:2] == 5'd0, "position reported on error")
    `CHK_IMPLY(a_fill_bound, clk, rst_n, m_tvalid,
        (CAPACITY > 31) || (m_tdata[11:7] <= CAPACITY), "fill count above capacity")

endmodule

bind ordered_array_list oal_checker #(
    .CAPACITY (CAPACITY)
) u_oal_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
